// ===== rtl/zrss_pkg.sv =====
// Shared types and constants for the ZIP record stream scanner.
package zrss_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } in_t;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [39:0] record_offset;
        logic [31:0] record_size;
        logic [1:0]  halt_reason;
        logic        last_of_run;
    } out_t;

    typedef enum logic [1:0] {
        PH_SIG,
        PH_HDR,
        PH_SKIP,
        PH_HALT
    } phase_t;

    typedef enum logic [1:0] {
        REC_LOCAL,
        REC_CENTRAL,
        REC_END
    } rec_t;

    localparam logic [2:0] KIND_LOCAL   = 3'd0;
    localparam logic [2:0] KIND_DATA    = 3'd1;
    localparam logic [2:0] KIND_CENTRAL = 3'd2;
    localparam logic [2:0] KIND_END     = 3'd3;
    localparam logic [2:0] KIND_HALT    = 3'd4;

    localparam logic [1:0] REASON_NONE  = 2'd0;
    localparam logic [1:0] REASON_SIG   = 2'd1;
    localparam logic [1:0] REASON_ZIP64 = 2'd2;

    localparam logic [31:0] SIG_LOCAL   = 32'h504B0304;
    localparam logic [31:0] SIG_CENTRAL = 32'h504B0102;
    localparam logic [31:0] SIG_END     = 32'h504B0506;
    localparam logic [31:0] SIZE_ZIP64  = 32'hFFFFFFFF;

    localparam logic [31:0] LOCAL_FIXED   = 32'd30;
    localparam logic [31:0] CENTRAL_FIXED = 32'd46;
    localparam logic [31:0] END_FIXED     = 32'd22;

    // header field positions; POS_NONE is beyond any 6-bit position
    localparam logic [6:0] POS_NONE   = 7'd64;
    localparam logic [6:0] LOC_CS     = 7'd18;
    localparam logic [6:0] LOC_US     = 7'd22;
    localparam logic [6:0] LOC_NL     = 7'd26;
    localparam logic [6:0] LOC_EL     = 7'd28;
    localparam logic [5:0] LOC_LAST   = 6'd29;
    localparam logic [6:0] CEN_CS     = 7'd20;
    localparam logic [6:0] CEN_US     = 7'd24;
    localparam logic [6:0] CEN_NL     = 7'd28;
    localparam logic [6:0] CEN_EL     = 7'd30;
    localparam logic [6:0] CEN_CL     = 7'd32;
    localparam logic [5:0] CEN_LAST   = 6'd45;
    localparam logic [6:0] END_CL     = 7'd20;
    localparam logic [5:0] END_LAST   = 6'd21;
    localparam logic [5:0] SIG_LAST   = 6'd3;
    localparam logic [5:0] HDR_FIRST  = 6'd4;

    localparam int QUEUE_DEPTH = 4;

    // one parsed event: one result, or a local header pair
    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  reason;
        logic        two;
        logic [31:0] size;
        logic [17:0] var_len;
        logic [31:0] data_size;
    } evt_t;

endpackage

// ===== rtl/zrss_front.sv =====
// Front end: byte parser that classifies records and produces events.
module zrss_front #(
    parameter int OFFSET_BITS = 40
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  zrss_pkg::in_t          byte_in,
    output logic                   push,
    output zrss_pkg::evt_t         evt,
    output logic [OFFSET_BITS-1:0] evt_start
);

    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    zrss_pkg::phase_t       phase_reg, phase_next;
    zrss_pkg::rec_t         type_reg, type_next;
    logic [5:0]             pos_reg, pos_next;
    logic [31:0]            sig_reg, sig_next;
    logic [31:0]            csize_reg, csize_next;
    logic                   uones_reg, uones_next;
    logic [15:0]            nlen_reg, nlen_next;
    logic [15:0]            elen_reg, elen_next;
    logic [15:0]            clen_reg, clen_next;
    logic [32:0]            skip_reg, skip_next;

    logic [7:0]  b;
    logic [6:0]  p7;
    logic [6:0]  cs_pos, us_pos, nl_pos, el_pos, cl_pos;
    logic [5:0]  last_pos;
    logic [17:0] var_len;
    logic [32:0] skip_len;
    logic        emit;
    zrss_pkg::evt_t evt_c;

    assign b  = byte_in.data_byte;
    assign p7 = {1'b0, pos_reg};

    always_comb
    begin
        case (type_reg)
            zrss_pkg::REC_LOCAL:
            begin
                cs_pos = zrss_pkg::LOC_CS;  us_pos = zrss_pkg::LOC_US;
                nl_pos = zrss_pkg::LOC_NL;  el_pos = zrss_pkg::LOC_EL;
                cl_pos = zrss_pkg::POS_NONE; last_pos = zrss_pkg::LOC_LAST;
            end
            zrss_pkg::REC_CENTRAL:
            begin
                cs_pos = zrss_pkg::CEN_CS;  us_pos = zrss_pkg::CEN_US;
                nl_pos = zrss_pkg::CEN_NL;  el_pos = zrss_pkg::CEN_EL;
                cl_pos = zrss_pkg::CEN_CL;  last_pos = zrss_pkg::CEN_LAST;
            end
            default:
            begin
                cs_pos = zrss_pkg::POS_NONE; us_pos = zrss_pkg::POS_NONE;
                nl_pos = zrss_pkg::POS_NONE; el_pos = zrss_pkg::POS_NONE;
                cl_pos = zrss_pkg::END_CL;   last_pos = zrss_pkg::END_LAST;
            end
        endcase
    end

    always_comb
    begin
        offset_next = offset_reg + OFFSET_BITS'(1);
        start_next  = start_reg;
        phase_next  = phase_reg;
        type_next   = type_reg;
        pos_next    = pos_reg;
        sig_next    = sig_reg;
        csize_next  = csize_reg;
        uones_next  = uones_reg;
        nlen_next   = nlen_reg;
        elen_next   = elen_reg;
        clen_next   = clen_reg;
        skip_next   = skip_reg;
        emit        = 1'b0;
        evt_c       = '0;
        var_len     = '0;
        skip_len    = '0;

        case (phase_reg)
            zrss_pkg::PH_SIG:
            begin
                if (pos_reg == 6'd0)
                    start_next = offset_reg;
                sig_next = {sig_reg[23:0], b};
                if (pos_reg < zrss_pkg::SIG_LAST)
                    pos_next = pos_reg + 6'd1;
                else if (sig_next == zrss_pkg::SIG_LOCAL)
                begin
                    type_next = zrss_pkg::REC_LOCAL;
                    phase_next = zrss_pkg::PH_HDR;
                    pos_next = zrss_pkg::HDR_FIRST;
                end
                else if (sig_next == zrss_pkg::SIG_CENTRAL)
                begin
                    type_next = zrss_pkg::REC_CENTRAL;
                    phase_next = zrss_pkg::PH_HDR;
                    pos_next = zrss_pkg::HDR_FIRST;
                end
                else if (sig_next == zrss_pkg::SIG_END)
                begin
                    type_next = zrss_pkg::REC_END;
                    phase_next = zrss_pkg::PH_HDR;
                    pos_next = zrss_pkg::HDR_FIRST;
                end
                else
                begin
                    emit = 1'b1;
                    evt_c.kind = zrss_pkg::KIND_HALT;
                    evt_c.reason = zrss_pkg::REASON_SIG;
                    phase_next = zrss_pkg::PH_HALT;
                    pos_next = 6'd0;
                end
            end
            zrss_pkg::PH_HDR:
            begin
                // little-endian byte lanes; the low byte clears the upper lanes
                if (p7 == cs_pos)              csize_next = {24'd0, b};
                else if (p7 == cs_pos + 7'd1)  csize_next[15:8] = b;
                else if (p7 == cs_pos + 7'd2)  csize_next[23:16] = b;
                else if (p7 == cs_pos + 7'd3)  csize_next[31:24] = b;

                if (p7 == us_pos)
                    uones_next = (b == 8'hFF);
                else if (p7 == us_pos + 7'd1 || p7 == us_pos + 7'd2 ||
                         p7 == us_pos + 7'd3)
                    uones_next = uones_reg & (b == 8'hFF);

                if (p7 == nl_pos)              nlen_next = {8'd0, b};
                else if (p7 == nl_pos + 7'd1)  nlen_next[15:8] = b;
                if (p7 == el_pos)              elen_next = {8'd0, b};
                else if (p7 == el_pos + 7'd1)  elen_next[15:8] = b;
                if (p7 == cl_pos)              clen_next = {8'd0, b};
                else if (p7 == cl_pos + 7'd1)  clen_next[15:8] = b;

                case (type_reg)
                    zrss_pkg::REC_LOCAL:
                    begin
                        var_len  = 18'(nlen_next) + 18'(elen_next);
                        skip_len = 33'(var_len) + 33'(csize_next);
                    end
                    zrss_pkg::REC_CENTRAL:
                    begin
                        var_len  = 18'(nlen_next) + 18'(elen_next) + 18'(clen_next);
                        skip_len = 33'(var_len);
                    end
                    default:
                    begin
                        var_len  = 18'(clen_next);
                        skip_len = 33'(var_len);
                    end
                endcase

                if (pos_reg < last_pos)
                    pos_next = pos_reg + 6'd1;
                else if (type_reg != zrss_pkg::REC_END &&
                         (csize_next == zrss_pkg::SIZE_ZIP64 || uones_next))
                begin
                    emit = 1'b1;
                    evt_c.kind = zrss_pkg::KIND_HALT;
                    evt_c.reason = zrss_pkg::REASON_ZIP64;
                    phase_next = zrss_pkg::PH_HALT;
                    pos_next = 6'd0;
                end
                else
                begin
                    emit = 1'b1;
                    evt_c.var_len = var_len;
                    evt_c.data_size = csize_next;
                    case (type_reg)
                        zrss_pkg::REC_LOCAL:
                        begin
                            evt_c.kind = zrss_pkg::KIND_LOCAL;
                            evt_c.two  = 1'b1;
                            evt_c.size = 32'(var_len) + zrss_pkg::LOCAL_FIXED;
                        end
                        zrss_pkg::REC_CENTRAL:
                        begin
                            evt_c.kind = zrss_pkg::KIND_CENTRAL;
                            evt_c.size = 32'(var_len) + zrss_pkg::CENTRAL_FIXED;
                        end
                        default:
                        begin
                            evt_c.kind = zrss_pkg::KIND_END;
                            evt_c.size = 32'(var_len) + zrss_pkg::END_FIXED;
                        end
                    endcase
                    skip_next = skip_len;
                    pos_next = 6'd0;
                    phase_next = (skip_len == 33'd0) ? zrss_pkg::PH_SIG
                                                     : zrss_pkg::PH_SKIP;
                end
            end
            zrss_pkg::PH_SKIP:
            begin
                if (skip_reg != 33'd0)
                    skip_next = skip_reg - 33'd1;
                if (skip_next == 33'd0)
                begin
                    phase_next = zrss_pkg::PH_SIG;
                    pos_next = 6'd0;
                end
            end
            default:
            begin
                // halted: bytes are dropped until end of file
            end
        endcase

        if (byte_in.end_of_file)
        begin
            offset_next = '0;
            start_next  = '0;
            phase_next  = zrss_pkg::PH_SIG;
            type_next   = zrss_pkg::REC_LOCAL;
            pos_next    = '0;
            sig_next    = '0;
            csize_next  = '0;
            uones_next  = 1'b0;
            nlen_next   = '0;
            elen_next   = '0;
            clen_next   = '0;
            skip_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            start_reg  <= '0;
            phase_reg  <= zrss_pkg::PH_SIG;
            type_reg   <= zrss_pkg::REC_LOCAL;
            pos_reg    <= '0;
            sig_reg    <= '0;
            csize_reg  <= '0;
            uones_reg  <= 1'b0;
            nlen_reg   <= '0;
            elen_reg   <= '0;
            clen_reg   <= '0;
            skip_reg   <= '0;
        end
        else if (fire)
        begin
            offset_reg <= offset_next;
            start_reg  <= start_next;
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            pos_reg    <= pos_next;
            sig_reg    <= sig_next;
            csize_reg  <= csize_next;
            uones_reg  <= uones_next;
            nlen_reg   <= nlen_next;
            elen_reg   <= elen_next;
            clen_reg   <= clen_next;
            skip_reg   <= skip_next;
        end
    end

    // record start is already held when any event is produced
    assign push      = fire & emit;
    assign evt       = evt_c;
    assign evt_start = start_reg;

endmodule

// ===== rtl/zrss_queue.sv =====
// Small FIFO that decouples the parser from the result stage.
module zrss_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             not_empty
);

    localparam int PTR_BITS = $clog2(zrss_pkg::QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(zrss_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]    mem [zrss_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_BITS'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_BITS'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(zrss_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + PTR_BITS'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(zrss_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + PTR_BITS'(1);
            count_reg <= count_next;
        end
    end

    assign rdata     = mem[rd_ptr_reg];
    assign full      = (count_reg == CNT_BITS'(zrss_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);

endmodule

// ===== rtl/zrss_back.sv =====
// Back end: expands events into result records behind an output register.
module zrss_back #(
    parameter int OFFSET_BITS = 40
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   evt_valid,
    input  zrss_pkg::evt_t         evt,
    input  logic [OFFSET_BITS-1:0] evt_start,
    output logic                   pop,
    output logic                   rec_valid,
    input  logic                   rec_ready,
    output zrss_pkg::out_t         rec_req
);

    logic                   out_valid_reg, out_valid_next;
    zrss_pkg::out_t         out_reg, out_next;
    logic                   pend_reg, pend_next;
    logic [OFFSET_BITS-1:0] pend_ofs_reg, pend_ofs_next;
    logic [31:0]            pend_size_reg, pend_size_next;
    logic                   load;
    logic [63:0]            start_wide;
    logic [63:0]            pend_wide;

    assign start_wide = 64'(evt_start);
    assign pend_wide  = 64'(pend_ofs_reg);
    assign load       = !out_valid_reg || rec_ready;

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        pend_next      = pend_reg;
        pend_ofs_next  = pend_ofs_reg;
        pend_size_next = pend_size_reg;
        pop            = 1'b0;

        if (load)
        begin
            out_valid_next = pend_reg || evt_valid;
            if (pend_reg)
            begin
                // file data record following its local header
                out_next.record_kind   = zrss_pkg::KIND_DATA;
                out_next.record_offset = pend_wide[39:0];
                out_next.record_size   = pend_size_reg;
                out_next.halt_reason   = zrss_pkg::REASON_NONE;
                out_next.last_of_run   = 1'b1;
                pend_next = 1'b0;
            end
            else if (evt_valid)
            begin
                pop = 1'b1;
                out_next.record_kind   = evt.kind;
                out_next.record_offset = start_wide[39:0];
                out_next.record_size   = evt.size;
                out_next.halt_reason   = evt.reason;
                out_next.last_of_run   = !evt.two;
                pend_next      = evt.two;
                pend_ofs_next  = evt_start + OFFSET_BITS'(zrss_pkg::LOCAL_FIXED)
                                 + OFFSET_BITS'(evt.var_len);
                pend_size_next = evt.data_size;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg       <= out_next;
        pend_ofs_reg  <= pend_ofs_next;
        pend_size_reg <= pend_size_next;
    end

    assign rec_valid = out_valid_reg;
    assign rec_req   = out_reg;

endmodule

// ===== rtl/zip_record_stream_scanner_unit.sv =====
// ZIP record stream scanner: one archive byte per cycle, record descriptors out.
// Throughput: one byte per cycle; byte_ready drops only while the 4-entry event queue is full.
// Path: each result goes through the event queue, then the output register, to rec_valid; the file
// data record of a local header shows in the cycle after its header result is taken.
// Reset: asynchronous, active low; clears parser, queue and output valid, no clearing pass.
module zip_record_stream_scanner_unit #(
    parameter int OFFSET_BITS = 40
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           byte_valid,
    output logic           byte_ready,
    input  zrss_pkg::in_t  byte_req,
    output logic           rec_valid,
    input  logic           rec_ready,
    output zrss_pkg::out_t rec_req
);

    localparam int EVT_BITS = $bits(zrss_pkg::evt_t);
    localparam int Q_WIDTH  = EVT_BITS + OFFSET_BITS;

    logic                   fire;
    logic                   push;
    logic                   pop;
    logic                   q_full;
    logic                   q_valid;
    zrss_pkg::evt_t         f_evt;
    logic [OFFSET_BITS-1:0] f_start;
    logic [Q_WIDTH-1:0]     q_wdata;
    logic [Q_WIDTH-1:0]     q_rdata;
    zrss_pkg::evt_t         b_evt;
    logic [OFFSET_BITS-1:0] b_start;

    assign byte_ready = !q_full;
    assign fire       = byte_valid && byte_ready;
    assign q_wdata    = {f_start, f_evt};
    assign b_evt      = q_rdata[EVT_BITS-1:0];
    assign b_start    = q_rdata[Q_WIDTH-1:EVT_BITS];

    zrss_front #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .byte_in  (byte_req),
        .push     (push),
        .evt      (f_evt),
        .evt_start(f_start)
    );

    zrss_queue #(
        .WIDTH(Q_WIDTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wdata    (q_wdata),
        .pop      (pop),
        .rdata    (q_rdata),
        .full     (q_full),
        .not_empty(q_valid)
    );

    zrss_back #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .evt_valid(q_valid),
        .evt      (b_evt),
        .evt_start(b_start),
        .pop      (pop),
        .rec_valid(rec_valid),
        .rec_ready(rec_ready),
        .rec_req  (rec_req)
    );

endmodule

// ===== rtl/zrss_checker.sv =====
// Port-level checks for the ZIP record stream scanner, bound to the top level.
module zrss_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           rec_valid,
    input logic           rec_ready,
    input zrss_pkg::out_t rec_req
);

    // a held result stays put until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && !rec_ready |=> rec_valid && $stable(rec_req))
        else $error("result changed while stalled");

    a_halt: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec_req.record_kind == zrss_pkg::KIND_HALT |->
        rec_req.record_size == 32'd0 && rec_req.halt_reason != zrss_pkg::REASON_NONE
        && rec_req.last_of_run)
        else $error("malformed halt result");

    a_reason: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec_req.record_kind != zrss_pkg::KIND_HALT |->
        rec_req.halt_reason == zrss_pkg::REASON_NONE)
        else $error("halt reason on a normal record");

    // local header is always followed by its file data record
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec_ready && rec_req.record_kind == zrss_pkg::KIND_LOCAL |=>
        rec_valid && rec_req.record_kind == zrss_pkg::KIND_DATA && rec_req.last_of_run)
        else $error("local header without file data record");

    a_local: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec_req.record_kind == zrss_pkg::KIND_LOCAL |->
        !rec_req.last_of_run && rec_req.record_size >= zrss_pkg::LOCAL_FIXED)
        else $error("bad local header result");

endmodule

bind zip_record_stream_scanner_unit zrss_checker u_zrss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .rec_valid(rec_valid),
    .rec_ready(rec_ready),
    .rec_req  (rec_req)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking testbench for the ZIP record stream scanner: directed and random archive streams.
module testbench;

    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_BYTES = 850;
    localparam int TAIL_CYCLES  = 16;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic byte_valid = 1'b0;
    logic byte_ready;
    zrss_pkg::in_t  byte_req = '0;
    logic rec_valid;
    logic rec_ready = 1'b0;
    zrss_pkg::out_t rec_req;

    zip_record_stream_scanner_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_req   (byte_req),
        .rec_valid  (rec_valid),
        .rec_ready  (rec_ready),
        .rec_req    (rec_req)
    );

    always #1 clk = ~clk;

    // parser mirror
    logic [39:0]      p_offset;
    zrss_pkg::phase_t p_phase;
    logic [5:0]       p_pos;
    logic [31:0]      p_sig;
    zrss_pkg::rec_t   p_rec;
    logic [39:0]      p_start;
    logic [31:0]      p_csize;
    logic             p_uones;
    logic [15:0]      p_nlen;
    logic [15:0]      p_elen;
    logic [15:0]      p_clen;
    logic [32:0]      p_skip;

    zrss_pkg::out_t expected_recs[$];
    logic [7:0] file_q[$];

    int errors = 0;
    int bytes_in = 0;
    int files_done = 0;
    int recs_checked = 0;
    int kinds_seen[5] = '{default: 0};
    int hold_requests = 0;
    int holds_taken = 0;
    int hold_left = 0;
    int held_total = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;

    task automatic clear_parser();
        p_offset = '0;
        p_phase  = zrss_pkg::PH_SIG;
        p_pos    = '0;
        p_sig    = '0;
        p_rec    = zrss_pkg::REC_LOCAL;
        p_start  = '0;
        p_csize  = '0;
        p_uones  = 1'b0;
        p_nlen   = '0;
        p_elen   = '0;
        p_clen   = '0;
        p_skip   = '0;
    endtask

    function automatic zrss_pkg::out_t descr(input logic [2:0] kind,
                                             input logic [39:0] ofs,
                                             input logic [31:0] len,
                                             input logic [1:0] why);
        zrss_pkg::out_t r;
        r.record_kind   = kind;
        r.record_offset = ofs;
        r.record_size   = len;
        r.halt_reason   = why;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    task automatic begin_skip(input logic [32:0] n);
        p_skip = n;
        p_pos  = '0;
        if (n == 0)
            p_phase = zrss_pkg::PH_SIG;
        else
            p_phase = zrss_pkg::PH_SKIP;
    endtask

    // advance the mirror by one archive byte and queue the records it yields
    task automatic predict_byte(input zrss_pkg::in_t it);
        logic [7:0]  b;
        logic [17:0] var_len;
        int pi, cs, us, nl, el, cl, lastp, n;
        zrss_pkg::out_t res[2];
        b  = it.data_byte;
        pi = p_pos;
        n  = 0;
        case (p_phase)
            zrss_pkg::PH_SIG:
            begin
                if (pi == 0)
                    p_start = p_offset;
                p_sig = {p_sig[23:0], b};
                if (pi < zrss_pkg::SIG_LAST)
                    p_pos = p_pos + 1'b1;
                else if (p_sig == zrss_pkg::SIG_LOCAL)
                begin
                    p_rec = zrss_pkg::REC_LOCAL;
                    p_phase = zrss_pkg::PH_HDR;
                    p_pos = zrss_pkg::HDR_FIRST;
                end
                else if (p_sig == zrss_pkg::SIG_CENTRAL)
                begin
                    p_rec = zrss_pkg::REC_CENTRAL;
                    p_phase = zrss_pkg::PH_HDR;
                    p_pos = zrss_pkg::HDR_FIRST;
                end
                else if (p_sig == zrss_pkg::SIG_END)
                begin
                    p_rec = zrss_pkg::REC_END;
                    p_phase = zrss_pkg::PH_HDR;
                    p_pos = zrss_pkg::HDR_FIRST;
                end
                else
                begin
                    res[n] = descr(zrss_pkg::KIND_HALT, p_start, '0, zrss_pkg::REASON_SIG);
                    n++;
                    p_phase = zrss_pkg::PH_HALT;
                    p_pos = '0;
                end
            end
            zrss_pkg::PH_HDR:
            begin
                case (p_rec)
                    zrss_pkg::REC_LOCAL:
                    begin
                        cs = zrss_pkg::LOC_CS; us = zrss_pkg::LOC_US;
                        nl = zrss_pkg::LOC_NL; el = zrss_pkg::LOC_EL;
                        cl = zrss_pkg::POS_NONE; lastp = zrss_pkg::LOC_LAST;
                    end
                    zrss_pkg::REC_CENTRAL:
                    begin
                        cs = zrss_pkg::CEN_CS; us = zrss_pkg::CEN_US;
                        nl = zrss_pkg::CEN_NL; el = zrss_pkg::CEN_EL;
                        cl = zrss_pkg::CEN_CL; lastp = zrss_pkg::CEN_LAST;
                    end
                    default:
                    begin
                        cs = zrss_pkg::POS_NONE; us = zrss_pkg::POS_NONE;
                        nl = zrss_pkg::POS_NONE; el = zrss_pkg::POS_NONE;
                        cl = zrss_pkg::END_CL; lastp = zrss_pkg::END_LAST;
                    end
                endcase
                if (pi == cs)
                    p_csize = {24'h0, b};
                else if (pi > cs && pi < cs + 4)
                    p_csize[8 * (pi - cs) +: 8] = b;
                if (pi == us)
                    p_uones = (b == 8'hFF);
                else if (pi > us && pi < us + 4)
                    p_uones = p_uones && (b == 8'hFF);
                if (pi == nl)
                    p_nlen = {8'h0, b};
                else if (pi == nl + 1)
                    p_nlen[15:8] = b;
                if (pi == el)
                    p_elen = {8'h0, b};
                else if (pi == el + 1)
                    p_elen[15:8] = b;
                if (pi == cl)
                    p_clen = {8'h0, b};
                else if (pi == cl + 1)
                    p_clen[15:8] = b;

                if (pi < lastp)
                    p_pos = p_pos + 1'b1;
                else if (p_rec != zrss_pkg::REC_END &&
                         (p_csize == zrss_pkg::SIZE_ZIP64 || p_uones))
                begin
                    res[n] = descr(zrss_pkg::KIND_HALT, p_start, '0, zrss_pkg::REASON_ZIP64);
                    n++;
                    p_phase = zrss_pkg::PH_HALT;
                    p_pos = '0;
                end
                else if (p_rec == zrss_pkg::REC_LOCAL)
                begin
                    var_len = 18'(p_nlen) + 18'(p_elen);
                    res[0] = descr(zrss_pkg::KIND_LOCAL, p_start,
                                   zrss_pkg::LOCAL_FIXED + 32'(var_len), zrss_pkg::REASON_NONE);
                    res[1] = descr(zrss_pkg::KIND_DATA,
                                   p_start + 40'(zrss_pkg::LOCAL_FIXED) + 40'(var_len),
                                   p_csize, zrss_pkg::REASON_NONE);
                    n = 2;
                    begin_skip(33'(var_len) + 33'(p_csize));
                end
                else if (p_rec == zrss_pkg::REC_CENTRAL)
                begin
                    var_len = 18'(p_nlen) + 18'(p_elen) + 18'(p_clen);
                    res[n] = descr(zrss_pkg::KIND_CENTRAL, p_start,
                                   zrss_pkg::CENTRAL_FIXED + 32'(var_len),
                                   zrss_pkg::REASON_NONE);
                    n++;
                    begin_skip(33'(var_len));
                end
                else
                begin
                    res[n] = descr(zrss_pkg::KIND_END, p_start,
                                   zrss_pkg::END_FIXED + 32'(p_clen), zrss_pkg::REASON_NONE);
                    n++;
                    begin_skip(33'(p_clen));
                end
            end
            zrss_pkg::PH_SKIP:
            begin
                if (p_skip > 0)
                    p_skip = p_skip - 1'b1;
                if (p_skip == 0)
                begin
                    p_phase = zrss_pkg::PH_SIG;
                    p_pos = '0;
                end
            end
            default: ;
        endcase
        if (n > 0)
            res[n - 1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            expected_recs.push_back(res[i]);
        p_offset = p_offset + 1'b1;
        if (it.end_of_file)
            clear_parser();
    endtask

    task automatic report_bad(input string what, input zrss_pkg::out_t want,
                              input zrss_pkg::out_t got);
        errors++;
        if (errors <= 10)
            $display("%0t %s: expected kind %0d ofs 0x%0h len %0d reason %0d last %0d",
                     $time, what, want.record_kind, want.record_offset, want.record_size,
                     want.halt_reason, want.last_of_run,
                     "; got kind %0d ofs 0x%0h len %0d reason %0d last %0d",
                     got.record_kind, got.record_offset, got.record_size,
                     got.halt_reason, got.last_of_run);
    endtask

    // predict on each accepted byte, then check each accepted record
    always @(posedge clk)
    begin : monitor
        zrss_pkg::out_t want;
        if (rst_n && byte_valid && byte_ready)
        begin
            predict_byte(byte_req);
            bytes_in++;
            if (byte_req.end_of_file)
                files_done++;
        end
        if (rst_n && rec_valid && rec_ready)
        begin
            if (expected_recs.size() == 0)
                report_bad("record with none pending", '0, rec_req);
            else
            begin
                want = expected_recs.pop_front();
                recs_checked++;
                if (want.record_kind <= zrss_pkg::KIND_HALT)
                    kinds_seen[want.record_kind]++;
                if (rec_req.record_kind !== want.record_kind ||
                    rec_req.record_offset !== want.record_offset ||
                    rec_req.record_size !== want.record_size ||
                    rec_req.halt_reason !== want.halt_reason ||
                    rec_req.last_of_run !== want.last_of_run)
                    report_bad("record mismatch", want, rec_req);
            end
        end
    end

    // output side: random stalls, long holds on request
    always @(posedge clk)
    begin : receiver
        if (hold_left > 0)
        begin
            hold_left--;
            rec_ready <= 1'b0;
        end
        else if (holds_taken != hold_requests)
        begin
            holds_taken++;
            hold_left = HOLD_CYCLES - 1;
            held_total += HOLD_CYCLES;
            rec_ready <= 1'b0;
        end
        else if (calm)
            rec_ready <= 1'b1;
        else
            rec_ready <= ($urandom_range(0, 99) >= 9);
    end

    always @(posedge clk)
    begin : stall_watch
        if (!rst_n || (byte_valid && byte_ready) || (rec_valid && rec_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("no request moved for %0d cycles, %0d records pending",
                         STALL_LIMIT, expected_recs.size());
                $display("[zip_record_stream_scanner_unit] ERROR");
                $finish;
            end
        end
    end

    // one archive byte per request; valid stays up into the next call
    task automatic send_byte(input logic [7:0] b, input logic eof);
        if (!calm)
            while ($urandom_range(0, 99) < 9)
            begin
                byte_valid <= 1'b0;
                @(posedge clk);
            end
        byte_valid <= 1'b1;
        byte_req <= '{data_byte: b, end_of_file: eof};
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
    endtask

    task automatic send_file(input bit eof_last);
        for (int i = 0; i < file_q.size(); i++)
            send_byte(file_q[i], eof_last && (i == file_q.size() - 1));
        file_q.delete();
    endtask

    task automatic add_le(input logic [31:0] v, input int nb);
        for (int i = 0; i < nb; i++)
            file_q.push_back(v[8 * i +: 8]);
    endtask

    // signatures go out most significant byte first
    task automatic add_sig(input logic [31:0] s);
        for (int i = 3; i >= 0; i--)
            file_q.push_back(s[8 * i +: 8]);
    endtask

    task automatic add_noise(input int nb);
        for (int i = 0; i < nb; i++)
            file_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_local(input logic [31:0] csz, input logic [31:0] usz,
                             input logic [15:0] nl, input logic [15:0] el, input bit body);
        add_sig(zrss_pkg::SIG_LOCAL);
        add_noise(14);
        add_le(csz, 4);
        add_le(usz, 4);
        add_le(nl, 2);
        add_le(el, 2);
        if (body)
            add_noise(nl + el + csz);
    endtask

    task automatic add_central(input logic [31:0] csz, input logic [31:0] usz,
                               input logic [15:0] nl, input logic [15:0] el,
                               input logic [15:0] cl, input bit body);
        add_sig(zrss_pkg::SIG_CENTRAL);
        add_noise(16);
        add_le(csz, 4);
        add_le(usz, 4);
        add_le(nl, 2);
        add_le(el, 2);
        add_le(cl, 2);
        add_noise(12);
        if (body)
            add_noise(nl + el + cl);
    endtask

    // w fills the directory size and offset words
    task automatic add_end(input logic [15:0] cl, input logic [31:0] w, input bit body);
        add_sig(zrss_pkg::SIG_END);
        add_noise(8);
        add_le(w, 4);
        add_le(w, 4);
        add_le(cl, 2);
        if (body)
            add_noise(cl);
    endtask

    task automatic test_directed();
        // ordinary records, empty ones too; the end record lands on the end-of-file byte
        add_local(0, 0, 0, 0, 1'b1);
        add_local(5, 7, 3, 2, 1'b1);
        add_central(5, 9, 3, 1, 2, 1'b1);
        add_central(0, 0, 0, 0, 0, 1'b1);
        add_end(0, $urandom, 1'b1);
        send_file(1'b1);
        // end record is never checked for zip64
        add_end(3, zrss_pkg::SIZE_ZIP64, 1'b1);
        send_file(1'b1);
        // zip64 markers; everything after the halt is ignored
        add_local(zrss_pkg::SIZE_ZIP64, 3, 1, 1, 1'b0);
        add_noise(6);
        add_end(0, 0, 1'b1);
        send_file(1'b1);
        add_local(3, zrss_pkg::SIZE_ZIP64, 0, 0, 1'b0);
        add_noise(3);
        send_file(1'b1);
        add_central(zrss_pkg::SIZE_ZIP64, 0, 0, 0, 0, 1'b0);
        send_file(1'b1);
        add_central(1, zrss_pkg::SIZE_ZIP64, 0, 0, 0, 1'b0);
        add_noise(2);
        send_file(1'b1);
        // one byte short of all ones is a normal size
        add_local(2, 32'hFFFF00FF, 0, 0, 1'b1);
        send_file(1'b1);
        // largest sizes, file cut right after the header
        add_local(32'hFFFFFFFE, 32'h0, 16'hFFFF, 16'hFFFF, 1'b0);
        send_file(1'b1);
        add_central(32'hFFFFFFFE, 32'hFFFFFFFE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_file(1'b1);
        add_end(16'hFFFF, zrss_pkg::SIZE_ZIP64, 1'b0);
        send_file(1'b1);
        // unknown signatures
        add_sig(zrss_pkg::SIG_LOCAL ^ 32'h1);
        add_noise(4);
        add_local(0, 0, 0, 0, 1'b1);
        send_file(1'b1);
        add_sig(32'h0);
        send_file(1'b1);
        // truncated inside a signature, a header and a body
        add_sig(zrss_pkg::SIG_LOCAL);
        repeat (2) void'(file_q.pop_back());
        send_file(1'b1);
        add_central(0, 0, 0, 0, 0, 1'b0);
        repeat (20) void'(file_q.pop_back());
        send_file(1'b1);
        add_local(8, 8, 2, 2, 1'b1);
        repeat (5) void'(file_q.pop_back());
        send_file(1'b1);
        // no end-of-file mark: offsets run on into the next file
        add_end(0, 0, 1'b1);
        send_file(1'b0);
        add_local(1, 1, 1, 1, 1'b1);
        send_file(1'b1);
    endtask

    // receiver holds off while short records keep coming, so the input backs up
    task automatic test_fill_stall();
        hold_requests++;
        repeat (12) add_local(0, 0, 0, 0, 1'b1);
        send_file(1'b1);
    endtask

    task automatic random_file();
        int nrec, pick, mark, cut, which;
        bit stop;
        logic [31:0] usz, csz, sig;
        nrec = $urandom_range(1, 6);
        stop = 1'b0;
        for (int r = 0; r < nrec && !stop; r++)
        begin
            pick = $urandom_range(0, 99);
            mark = file_q.size();
            if ($urandom_range(0, 3) == 0)
                usz = zrss_pkg::SIZE_ZIP64 ^ (32'hFF << (8 * $urandom_range(0, 3)));
            else
                usz = $urandom;
            if (pick < 30)
                add_local($urandom_range(0, 20), usz, $urandom_range(0, 5),
                          $urandom_range(0, 4), 1'b1);
            else if (pick < 50)
                add_central($urandom_range(0, 20), usz, $urandom_range(0, 5),
                            $urandom_range(0, 4), $urandom_range(0, 4), 1'b1);
            else if (pick < 62)
                add_end($urandom_range(0, 6), $urandom, 1'b1);
            else if (pick < 74)
            begin
                which = $urandom_range(0, 2);
                csz = (which != 1) ? zrss_pkg::SIZE_ZIP64 : 32'($urandom_range(0, 9));
                usz = (which != 0) ? zrss_pkg::SIZE_ZIP64 : 32'($urandom_range(0, 9));
                if ($urandom_range(0, 1))
                    add_local(csz, usz, $urandom_range(0, 3), $urandom_range(0, 3), 1'b0);
                else
                    add_central(csz, usz, $urandom_range(0, 3), 0, 0, 1'b0);
                add_noise($urandom_range(0, 10));
                stop = 1'b1;
            end
            else if (pick < 82)
            begin
                if ($urandom_range(0, 1))
                    sig = $urandom;
                else
                    sig = {zrss_pkg::SIG_LOCAL[31:8], 8'($urandom_range(0, 255))};
                if (sig == zrss_pkg::SIG_LOCAL || sig == zrss_pkg::SIG_CENTRAL ||
                    sig == zrss_pkg::SIG_END)
                    sig = sig ^ 32'h80;
                add_sig(sig);
                add_noise($urandom_range(0, 8));
                stop = 1'b1;
            end
            else if (pick < 92)
            begin
                case ($urandom_range(0, 2))
                    0: add_local($urandom_range(0, 12), usz, $urandom_range(0, 4),
                                 $urandom_range(0, 4), 1'b1);
                    1: add_central($urandom_range(0, 12), usz, $urandom_range(0, 4),
                                   $urandom_range(0, 4), $urandom_range(0, 4), 1'b1);
                    default: add_end($urandom_range(0, 6), $urandom, 1'b1);
                endcase
                cut = $urandom_range(1, file_q.size() - mark - 1);
                while (file_q.size() > mark + cut)
                    void'(file_q.pop_back());
                stop = 1'b1;
            end
            else if (pick < 96)
            begin
                csz = $urandom;
                if (csz == zrss_pkg::SIZE_ZIP64)
                    csz = csz - 1;
                if ($urandom_range(0, 1))
                    add_local(csz, usz, $urandom_range(0, 16'hFFFF),
                              $urandom_range(0, 16'hFFFF), 1'b0);
                else
                    add_central(csz, usz, $urandom_range(0, 16'hFFFF),
                                $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF),
                                1'b0);
                add_noise($urandom_range(0, 3));
                stop = 1'b1;
            end
            else
            begin
                add_noise($urandom_range(1, 12));
                stop = 1'b1;
            end
        end
        send_file(stop || $urandom_range(0, 9) != 0);
    endtask

    task automatic test_random_files();
        int first;
        first = bytes_in;
        while (bytes_in - first < RANDOM_BYTES)
        begin
            // a stretch with no stalls on either side
            calm = (bytes_in - first > 300) && (bytes_in - first < 650);
            random_file();
        end
        calm = 1'b0;
    endtask

    initial
    begin
        clear_parser();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_fill_stall();
        test_random_files();
        byte_valid <= 1'b0;
        while (expected_recs.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("run: %0d archive bytes over %0d files, %0d records checked, %0d mismatches",
                 bytes_in, files_done, recs_checked, errors);
        $display("kinds: local %0d, data %0d, central %0d, end %0d, halt %0d; held %0d cycles",
                 kinds_seen[zrss_pkg::KIND_LOCAL], kinds_seen[zrss_pkg::KIND_DATA],
                 kinds_seen[zrss_pkg::KIND_CENTRAL], kinds_seen[zrss_pkg::KIND_END],
                 kinds_seen[zrss_pkg::KIND_HALT], held_total);
        if (errors == 0)
            $display("[zip_record_stream_scanner_unit] OK");
        else
            $display("[zip_record_stream_scanner_unit] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/zrss_pkg.sv
rtl/zrss_front.sv
rtl/zrss_queue.sv
rtl/zrss_back.sv
rtl/zip_record_stream_scanner_unit.sv
rtl/zrss_checker.sv
bench/testbench.sv
